@@ design/assert_macros.svh @@
// Assertion helpers used by the deframer top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

@@ design/sfd_pkg.sv @@
package sfd_pkg;

   // Parser phase codes
   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_SYNC1   = 3'd1;
   localparam logic [2:0] PH_SYNC2   = 3'd2;
   localparam logic [2:0] PH_ID      = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CHECK   = 3'd5;

   // Result event codes
   localparam logic [1:0] EV_PAYLOAD = 2'd0;
   localparam logic [1:0] EV_ACCEPT  = 2'd1;
   localparam logic [1:0] EV_REJECT  = 2'd2;
   localparam logic [1:0] EV_SYNCERR = 2'd3;

   // Register map
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_SECOND = 1'd1;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'd170;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'd85;

   localparam logic [15:0] ERR_MAX = 16'hFFFF;
   localparam logic [7:0]  CNT_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  payload_byte;
      logic [7:0]  frame_id;
      logic [7:0]  byte_position;
      logic [15:0] error_total;
   } rsp_type;

endpackage

@@ design/sfd_parser.sv @@
// Frame parser: one byte of state update per transfer.
module sfd_parser (
   input  logic            clock,
   input  logic            reset,
   input  sfd_pkg::cfg_type cfg,
   input  logic            in_valid,
   input  logic [7:0]      in_byte,
   output logic            res_valid,
   output sfd_pkg::rsp_type res
);

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [15:0] err_ff, err_in;
   logic [15:0] err_bump;
   logic [7:0]  sum_add;
   logic [7:0]  cnt_next;

   assign err_bump = (err_ff == sfd_pkg::ERR_MAX) ? err_ff : err_ff + 16'd1;
   assign sum_add  = sum_ff + in_byte;
   assign cnt_next = (cnt_ff == sfd_pkg::CNT_MAX) ? cnt_ff : cnt_ff + 8'd1;

   // Next state and result for the byte on the input
   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      res_valid = 1'b0;
      res       = '0;
      case (phase_ff)
         sfd_pkg::PH_SYNC1: begin
            if (in_byte == cfg.sync_second) begin
               phase_in = sfd_pkg::PH_SYNC2;
               sum_in   = 8'd0;
            end else begin
               err_in         = err_bump;
               phase_in       = sfd_pkg::PH_HUNT;
               res_valid      = 1'b1;
               res.event_kind = sfd_pkg::EV_SYNCERR;
            end
         end
         sfd_pkg::PH_SYNC2: begin
            id_in    = in_byte;
            sum_in   = sum_add;
            phase_in = sfd_pkg::PH_ID;
         end
         sfd_pkg::PH_ID: begin
            len_in   = in_byte;
            sum_in   = sum_add;
            cnt_in   = 8'd0;
            phase_in = sfd_pkg::PH_PAYLOAD;
         end
         sfd_pkg::PH_PAYLOAD: begin
            sum_in = sum_add;
            cnt_in = cnt_next;
            // a zero length still ends after the first payload byte
            if (cnt_next >= len_ff) phase_in = sfd_pkg::PH_CHECK;
            res_valid         = 1'b1;
            res.event_kind    = sfd_pkg::EV_PAYLOAD;
            res.payload_byte  = in_byte;
            res.frame_id      = id_ff;
            res.byte_position = cnt_ff;
         end
         sfd_pkg::PH_CHECK: begin
            phase_in          = sfd_pkg::PH_HUNT;
            res_valid         = 1'b1;
            res.frame_id      = id_ff;
            res.byte_position = cnt_ff;
            if (in_byte == sum_ff) begin
               res.event_kind = sfd_pkg::EV_ACCEPT;
            end else begin
               err_in         = err_bump;
               res.event_kind = sfd_pkg::EV_REJECT;
            end
         end
         default: begin
            // hunting; unused codes fall back here too
            phase_in = (in_byte == cfg.sync_first) ? sfd_pkg::PH_SYNC1 : sfd_pkg::PH_HUNT;
         end
      endcase
      res.error_total = err_in;
      res_valid       = res_valid & in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfd_pkg::PH_HUNT;
         sum_ff   <= 8'd0;
         id_ff    <= 8'd0;
         len_ff   <= 8'd0;
         cnt_ff   <= 8'd0;
         err_ff   <= 16'd0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
      end
   end

endmodule

@@ design/sfd_out_buf.sv @@
// Result register with one skid entry behind it.
module sfd_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  sfd_pkg::rsp_type in_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_stall,
   output sfd_pkg::rsp_type out_data
);

   logic             out_valid_ff;
   logic             skid_valid_ff;
   sfd_pkg::rsp_type out_data_ff;
   sfd_pkg::rsp_type skid_data_ff;
   logic             out_free;

   assign out_free  = !out_valid_ff || !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Control: skid drains first; new results only arrive while skid is empty
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (in_valid) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

@@ design/sync_frame_deframer_top.sv @@
// Streaming deframer for frames of two sync bytes, an ID byte, a length byte, the payload and
// a modulo-256 checksum over ID, length and payload. One received byte is taken per clock
// while req_stall is low; the parser updates its state in the same cycle a byte is transferred
// in, and any event (payload byte, frame accept, checksum reject, sync error) appears on the
// rsp_ channel from the result register. While rsp_stall holds a result in that register,
// bytes that make no event (hunting, ID, length) keep flowing and one more event is parked
// in a second entry; req_stall then rises until the backlog drains. Sync byte values are set
// through the csr_ port by the user while the block is idle; the block does not enforce this.
module sync_frame_deframer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_event_kind,
   output logic [7:0]                          rsp_payload_byte,
   output logic [7:0]                          rsp_frame_id,
   output logic [7:0]                          rsp_byte_position,
   output logic [15:0]                         rsp_error_total,
   input  logic                                csr_wr_en,
   input  logic [sfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                          csr_wdata
);

`include "assert_macros.svh"

   sfd_pkg::cfg_type cfg_ff;
   sfd_pkg::rsp_type res;
   sfd_pkg::rsp_type rsp_data;
   logic             res_valid;
   logic             req_take;
   logic             buf_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= sfd_pkg::SYNC_FIRST_RESET;
         cfg_ff.sync_second <= sfd_pkg::SYNC_SECOND_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sfd_pkg::CSR_SYNC_FIRST:  cfg_ff.sync_first  <= csr_wdata;
            sfd_pkg::CSR_SYNC_SECOND: cfg_ff.sync_second <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = buf_full;
   assign req_take  = req_valid && !req_stall;

   sfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_take),
      .in_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   sfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_event_kind    = rsp_data.event_kind;
   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_frame_id      = rsp_data.frame_id;
   assign rsp_byte_position = rsp_data.byte_position;
   assign rsp_error_total   = rsp_data.error_total;

   // A full skid entry always has a result waiting ahead of it
   `ASSERT_NEVER(a_skid_without_out, clock, reset,
      buf_full && !rsp_valid, "skid full, output empty")

   // Error events always carry a nonzero error count
   `ASSERT_CLK(a_err_counted, clock, reset,
      rsp_valid && (rsp_event_kind == sfd_pkg::EV_SYNCERR ||
      rsp_event_kind == sfd_pkg::EV_REJECT) |-> rsp_error_total != 16'd0,
      "error event with zero error count")

   // Only payload events carry a payload byte
   `ASSERT_CLK(a_payload_only, clock, reset,
      rsp_valid && rsp_event_kind != sfd_pkg::EV_PAYLOAD |-> rsp_payload_byte == 8'd0,
      "payload byte on non-payload event")

   // A result made while the output is stalled lands in the skid entry
   `ASSERT_CLK(a_skid_fill, clock, reset,
      rsp_valid && rsp_stall && res_valid |=> buf_full,
      "result lost under stall")

endmodule
